// ===== rtl/dtc_pkg.sv =====
// Package for the decimal text to cents parser: character codes, token and
// status types shared by the front end, the back end and the checker.
// No dependencies.
package dtc_pkg;

  localparam int CHAR_W = 8;
  localparam int MAG_W  = 63;
  localparam int AMT_W  = 64;
  localparam int FRAC_W = 3;

  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_COMMA = 8'h2C;
  localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

  // Largest magnitude, 2^63-1; the saturation value.
  localparam logic [MAG_W-1:0] MAG_MAX = {MAG_W{1'b1}};

  typedef enum logic [2:0] {
    CLS_END,
    CLS_DIGIT,
    CLS_SEP,
    CLS_MINUS,
    CLS_OTHER
  } char_class_t;

  typedef struct packed {
    char_class_t cls;
    logic [3:0]  digit;
  } token_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_SEP2    = 2'd1,
    ST_BADCHAR = 2'd2,
    ST_EMPTY   = 2'd3
  } status_t;

  typedef enum logic {
    BK_RUN,
    BK_SCALE
  } back_state_t;

endpackage

// ===== rtl/dtc_front.sv =====
// Front end of the parser: classifies each incoming character into a token
// and holds tokens in a two-entry queue for the back end. Uses dtc_pkg.
module dtc_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [dtc_pkg::CHAR_W-1:0]  character,
  input  logic                        character_valid,
  output logic                        character_stall,
  output dtc_pkg::token_t             tok,
  output logic                        tok_valid,
  input  logic                        tok_pop
);
  import dtc_pkg::*;

  token_t            cls_tok;
  token_t            entry [2];
  logic              wr_ptr;
  logic              rd_ptr;
  logic [1:0]        count;
  logic              push;

  always_comb begin
    cls_tok.digit = 4'(character - CH_ZERO);
    if (character == CH_NUL) begin
      cls_tok.cls = CLS_END;
    end else if (character >= CH_ZERO && character <= CH_NINE) begin
      cls_tok.cls = CLS_DIGIT;
    end else if (character == CH_COMMA || character == CH_DOT) begin
      cls_tok.cls = CLS_SEP;
    end else if (character == CH_MINUS) begin
      cls_tok.cls = CLS_MINUS;
    end else begin
      cls_tok.cls = CLS_OTHER;
    end
  end

  assign character_stall = (count == 2'd2);
  assign push            = character_valid && !character_stall;
  assign tok_valid       = (count != 2'd0);
  assign tok             = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= cls_tok;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (tok_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, tok_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== rtl/dtc_back.sv =====
// Back end of the parser: accumulates digits with saturation, scales missing
// fraction digits at the terminator and drives the result register. Uses dtc_pkg.
module dtc_back #(
  parameter int FRAC_DIGITS = 2
) (
  input  logic                       clk,
  input  logic                       rst,
  input  dtc_pkg::token_t            tok,
  input  logic                       tok_valid,
  output logic                       tok_pop,
  output logic                       result_valid,
  input  logic                       result_stall,
  output logic [dtc_pkg::AMT_W-1:0]  amount,
  output logic [1:0]                 status,
  output logic                       overflow
);
  import dtc_pkg::*;

  localparam logic [FRAC_W-1:0] FRAC_INIT = FRAC_W'(FRAC_DIGITS);

  // Returns {saturated, magnitude*10+d clipped to MAG_MAX}.
  function automatic logic [MAG_W:0] times_ten_plus(input logic [MAG_W-1:0] m,
                                                    input logic [3:0] d);
    logic [MAG_W+3:0] wide;
    wide = {1'b0, m, 3'b000} + {3'b000, m, 1'b0} + {{MAG_W{1'b0}}, d};
    if (|wide[MAG_W+3:MAG_W]) begin
      return {1'b1, MAG_MAX};
    end
    return {1'b0, wide[MAG_W-1:0]};
  endfunction

  back_state_t       state, state_next;
  logic [MAG_W-1:0]  mag, mag_next;
  logic [FRAC_W-1:0] frac_left, frac_left_next;
  logic              sep_seen, sep_seen_next;
  logic              negative, negative_next;
  logic              at_start, at_start_next;
  logic              ignoring, ignoring_next;
  status_t           err, err_next;
  logic              ovf_flag, ovf_flag_next;

  logic [3:0]        d_in;
  logic [MAG_W:0]    tt;
  logic              out_free;
  logic              load_out;
  logic              clear;
  logic [AMT_W-1:0]  amt_pos;
  logic [AMT_W-1:0]  amt_neg;
  logic [AMT_W-1:0]  amount_next;
  status_t           status_next;
  logic              overflow_next;

  assign d_in     = (state == BK_SCALE) ? 4'd0 : tok.digit;
  assign tt       = times_ten_plus(mag, d_in);
  assign out_free = !result_valid || !result_stall;
  assign amt_pos  = {1'b0, mag};
  assign amt_neg  = ~amt_pos + {{(AMT_W-1){1'b0}}, 1'b1};

  always_comb begin
    state_next     = state;
    mag_next       = mag;
    frac_left_next = frac_left;
    sep_seen_next  = sep_seen;
    negative_next  = negative;
    at_start_next  = at_start;
    ignoring_next  = ignoring;
    err_next       = err;
    ovf_flag_next  = ovf_flag;
    tok_pop        = 1'b0;
    load_out       = 1'b0;
    clear          = 1'b0;

    unique case (state)
      BK_RUN: begin
        if (tok_valid) begin
          if (tok.cls == CLS_END) begin
            if (at_start || err != ST_OK || frac_left == '0) begin
              if (out_free) begin
                tok_pop  = 1'b1;
                load_out = 1'b1;
                clear    = 1'b1;
              end
            end else begin
              tok_pop    = 1'b1;
              state_next = BK_SCALE;
            end
          end else begin
            tok_pop       = 1'b1;
            at_start_next = 1'b0;
            if (at_start && tok.cls == CLS_MINUS) begin
              negative_next = 1'b1;
            end else if (!ignoring) begin
              case (tok.cls)
                CLS_DIGIT: begin
                  mag_next = tt[MAG_W-1:0];
                  if (tt[MAG_W]) begin
                    ovf_flag_next = 1'b1;
                  end
                  if (sep_seen) begin
                    frac_left_next = frac_left - FRAC_W'(1);
                    if (frac_left == FRAC_W'(1)) begin
                      ignoring_next = 1'b1;
                    end
                  end
                end
                CLS_SEP: begin
                  if (sep_seen) begin
                    err_next      = ST_SEP2;
                    ignoring_next = 1'b1;
                  end else begin
                    sep_seen_next = 1'b1;
                  end
                end
                default: begin
                  err_next      = ST_BADCHAR;
                  ignoring_next = 1'b1;
                end
              endcase
            end
          end
        end
      end
      BK_SCALE: begin
        if (frac_left != '0) begin
          mag_next       = tt[MAG_W-1:0];
          frac_left_next = frac_left - FRAC_W'(1);
          if (tt[MAG_W]) begin
            ovf_flag_next = 1'b1;
          end
        end else if (out_free) begin
          load_out   = 1'b1;
          clear      = 1'b1;
          state_next = BK_RUN;
        end
      end
      default: begin
        state_next = BK_RUN;
      end
    endcase

    if (at_start) begin
      amount_next   = '0;
      status_next   = ST_EMPTY;
      overflow_next = 1'b0;
    end else if (err != ST_OK) begin
      amount_next   = '0;
      status_next   = err;
      overflow_next = 1'b0;
    end else begin
      amount_next   = negative ? amt_neg : amt_pos;
      status_next   = ST_OK;
      overflow_next = ovf_flag;
    end

    if (clear) begin
      mag_next       = '0;
      frac_left_next = FRAC_INIT;
      sep_seen_next  = 1'b0;
      negative_next  = 1'b0;
      at_start_next  = 1'b1;
      ignoring_next  = 1'b0;
      err_next       = ST_OK;
      ovf_flag_next  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_RUN;
      mag       <= '0;
      frac_left <= FRAC_INIT;
      sep_seen  <= 1'b0;
      negative  <= 1'b0;
      at_start  <= 1'b1;
      ignoring  <= 1'b0;
      err       <= ST_OK;
      ovf_flag  <= 1'b0;
    end else begin
      state     <= state_next;
      mag       <= mag_next;
      frac_left <= frac_left_next;
      sep_seen  <= sep_seen_next;
      negative  <= negative_next;
      at_start  <= at_start_next;
      ignoring  <= ignoring_next;
      err       <= err_next;
      ovf_flag  <= ovf_flag_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load_out) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      amount   <= amount_next;
      status   <= status_next;
      overflow <= overflow_next;
    end
  end

endmodule

// ===== rtl/decimal_text_to_cents.sv =====
// Top level of the decimal text to cents parser; instantiates dtc_front and
// dtc_back and depends on dtc_pkg.
//
// This block reads a decimal amount one ASCII character per beat and returns
// it as a signed 64-bit integer in units of 10^-FRAC_DIGITS (cents for the
// default of two). A leading '-' makes the value negative, one ',' or '.'
// separates the fraction, and a character of zero ends the string; only the
// terminator produces a result beat, carrying amount, status (ok, second
// separator, invalid character, empty string) and an overflow flag that
// marks a magnitude saturated at 2^63-1. After an error the rest of the
// string is skipped and the amount reads 0. The front end classifies each
// character and parks it in a two-entry queue, so up to two more characters
// are taken while the back end works or the result waits; after that the
// input stalls until the back end moves on. Ordinary characters go through
// at one per cycle, limited by the single times-ten-plus-digit adder, unless
// the back end is scaling or holding a result. A clean string's terminator
// makes the same adder scale in the missing zeros (FRAC_DIGITS minus the
// fraction digits given) one per cycle before the result register is loaded;
// a terminator after an error, of an empty string or after a full fraction
// loads it directly. The result register holds a beat until it is taken.
module decimal_text_to_cents #(
  parameter int FRAC_DIGITS = 2
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [dtc_pkg::CHAR_W-1:0] character,
  input  logic                       character_valid,
  output logic                       character_stall,
  output logic [dtc_pkg::AMT_W-1:0]  amount,
  output logic [1:0]                 status,
  output logic                       overflow,
  output logic                       result_valid,
  input  logic                       result_stall
);
  import dtc_pkg::*;

  // Token queue between the two halves.
  token_t tok;
  logic   tok_valid;
  logic   tok_pop;

  dtc_front u_front (
    .clk             (clk),
    .rst             (rst),
    .character       (character),
    .character_valid (character_valid),
    .character_stall (character_stall),
    .tok             (tok),
    .tok_valid       (tok_valid),
    .tok_pop         (tok_pop)
  );

  // The back end owns all parse state; it resets itself after every
  // terminator so the next string starts clean.
  dtc_back #(
    .FRAC_DIGITS (FRAC_DIGITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .tok          (tok),
    .tok_valid    (tok_valid),
    .tok_pop      (tok_pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .amount       (amount),
    .status       (status),
    .overflow     (overflow)
  );

endmodule

// ===== rtl/dtc_checker.sv =====
// Port-level checker for decimal_text_to_cents, bound to the top level.
// Depends on dtc_pkg.
module dtc_checker (
  input logic                       clk,
  input logic                       rst,
  input logic [dtc_pkg::AMT_W-1:0]  amount,
  input logic [1:0]                 status,
  input logic                       overflow,
  input logic                       result_valid,
  input logic                       result_stall
);
  import dtc_pkg::*;

  localparam logic [AMT_W-1:0] AMT_SAT_POS = {1'b0, MAG_MAX};
  localparam logic [AMT_W-1:0] AMT_SAT_NEG = {1'b1, {(MAG_W-1){1'b0}}, 1'b1};
  localparam logic [AMT_W-1:0] AMT_MIN     = {1'b1, {MAG_W{1'b0}}};

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(amount) &&
      $stable(status) && $stable(overflow))
    else $error("result beat changed while stalled");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && status != ST_OK |-> amount == '0 && !overflow)
    else $error("error or empty result carries a nonzero amount or overflow");

  a_sat_value: assert property (@(posedge clk) disable iff (rst)
    result_valid && overflow |-> amount == AMT_SAT_POS || amount == AMT_SAT_NEG)
    else $error("overflow flagged without a saturated amount");

  a_no_min: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> amount != AMT_MIN)
    else $error("amount outside the symmetric range");

endmodule

bind decimal_text_to_cents dtc_checker u_dtc_checker (.*);
